FILE: hdl/slic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_pkg: shared types for the slot info LRU cache
// Request and response beats, request function codes and fixed field widths.
// ----------------------------------------------------------------------------
package slic_pkg;

  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned AGE_W     = 32;
  localparam int unsigned PAYLOAD_W = 64;

  typedef enum logic [1:0] {
    FUNC_LOOKUP    = 2'd0,
    FUNC_INSERT    = 2'd1,
    FUNC_INVAL     = 2'd2,
    FUNC_INVAL_ALL = 2'd3
  } slic_func_e;

  typedef struct packed {
    slic_func_e             func;
    logic [SLOT_W-1:0]      slot;
    logic                   in_used;
    logic [PAYLOAD_W-1:0]   in_payload;
  } slic_req_t;

  typedef struct packed {
    logic                   hit;
    logic                   out_used;
    logic [PAYLOAD_W-1:0]   out_payload;
  } slic_rsp_t;

endpackage

FILE: hdl/slic_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_match: parallel slot compare
// Compares the request slot with every valid entry; reports all matches and
// the lowest matching index.
// ----------------------------------------------------------------------------
module slic_match #(
  parameter int unsigned ENTRIES = 4,
  parameter int unsigned IDX_W   = 2
) (
  input  logic [slic_pkg::SLOT_W-1:0] slot_i,
  input  logic [slic_pkg::SLOT_W-1:0] entry_slot_i [ENTRIES],
  input  logic [ENTRIES-1:0]          entry_valid_i,
  output logic [ENTRIES-1:0]          match_o,
  output logic                        hit_o,
  output logic [IDX_W-1:0]            hit_idx_o
);
  import slic_pkg::*;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_o[i] = entry_valid_i[i] && (entry_slot_i[i] == slot_i);
    end
  end

  // lowest index wins when duplicates exist
  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_o[i]) begin
        hit_o     = 1'b1;
        hit_idx_o = IDX_W'(i);
      end
    end
  end

endmodule

FILE: hdl/slic_victim_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slic_victim_sel: oldest entry search
// Comparator tree over the entry tickets; picks the smallest ticket, lowest
// index on a tie. Invalid entries hold ticket zero and so go first.
// ----------------------------------------------------------------------------
module slic_victim_sel #(
  parameter int unsigned ENTRIES = 4,
  parameter int unsigned IDX_W   = 2
) (
  input  logic [slic_pkg::AGE_W-1:0] age_i [ENTRIES],
  output logic [IDX_W-1:0]           victim_o
);
  import slic_pkg::*;

  localparam int unsigned LEVELS = $clog2(ENTRIES);
  localparam int unsigned LEAVES = 1 << LEVELS;

  logic [AGE_W-1:0] node_age [LEVELS+1][LEAVES];
  logic [IDX_W-1:0] node_idx [LEVELS+1][LEAVES];

  always_comb begin
    for (int n = 0; n < LEAVES; n++) begin
      // pad unused leaves on the right with the largest ticket
      if (n < ENTRIES) begin
        node_age[0][n] = age_i[n];
        node_idx[0][n] = IDX_W'(n);
      end else begin
        node_age[0][n] = '1;
        node_idx[0][n] = '0;
      end
    end
    for (int l = 1; l <= LEVELS; l++) begin
      for (int n = 0; n < LEAVES; n++) begin
        node_age[l][n] = '0;
        node_idx[l][n] = '0;
      end
      for (int n = 0; n < (LEAVES >> l); n++) begin
        // keep the left node unless the right one is strictly older
        if (node_age[l-1][2*n+1] < node_age[l-1][2*n]) begin
          node_age[l][n] = node_age[l-1][2*n+1];
          node_idx[l][n] = node_idx[l-1][2*n+1];
        end else begin
          node_age[l][n] = node_age[l-1][2*n];
          node_idx[l][n] = node_idx[l-1][2*n];
        end
      end
    end
  end

  assign victim_o = node_idx[LEVELS][0];

endmodule

FILE: hdl/slot_info_lru_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_info_lru_cache_core: fully associative slot info cache with LRU tickets
// Lookup, insert, invalidate and invalidate-all on ENTRIES entries held in
// flops; one response beat per request beat.
// ----------------------------------------------------------------------------
// Timing: the request is captured in the input register when it is taken; the
//   compare/update result goes into the response register, which drives the
//   response strobe.
// Throughput: one request per cycle; busy stays low, the entry state is
//   updated in the same cycle the request is evaluated.
// Reset: all tickets, slots, used flags and the ticket counter clear, so every
//   entry starts invalid. The response strobe cannot be stalled.
module slot_info_lru_cache_core #(
  parameter int unsigned ENTRIES       = 4,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  slic_pkg::slic_req_t req_i,
  output logic                rsp_valid_o,
  output slic_pkg::slic_rsp_t rsp_o
);
  import slic_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  logic                     req_valid_q;
  slic_req_t                req_q;

  logic [SLOT_W-1:0]        entry_slot_q    [ENTRIES];
  logic [SLOT_W-1:0]        entry_slot_d    [ENTRIES];
  logic [ENTRIES-1:0]       entry_used_q, entry_used_d;
  logic [AGE_W-1:0]         entry_age_q     [ENTRIES];
  logic [AGE_W-1:0]         entry_age_d     [ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] entry_payload_q [ENTRIES];
  logic [AGE_W-1:0]         age_counter_q, age_counter_d;

  logic [ENTRIES-1:0]       entry_valid;
  logic [ENTRIES-1:0]       match;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         victim;
  logic [AGE_W-1:0]         ticket_sum;
  logic [AGE_W-1:0]         ticket;
  logic                     do_insert;

  logic                     rsp_valid_q;
  slic_rsp_t                rsp_q, rsp_d;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      entry_valid[i] = (entry_age_q[i] != '0);
    end
  end

  slic_match #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_match (
    .slot_i        (req_q.slot),
    .entry_slot_i  (entry_slot_q),
    .entry_valid_i (entry_valid),
    .match_o       (match),
    .hit_o         (hit),
    .hit_idx_o     (hit_idx)
  );

  slic_victim_sel #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_victim (
    .age_i    (entry_age_q),
    .victim_o (victim)
  );

  // fresh ticket, skip zero on wrap
  assign ticket_sum = age_counter_q + AGE_W'(1);
  assign ticket     = (ticket_sum == '0) ? AGE_W'(1) : ticket_sum;

  always_comb begin
    entry_slot_d  = entry_slot_q;
    entry_used_d  = entry_used_q;
    entry_age_d   = entry_age_q;
    age_counter_d = age_counter_q;
    do_insert     = 1'b0;
    rsp_d         = '0;
    if (req_valid_q) begin
      case (req_q.func)
        FUNC_LOOKUP: begin
          if (hit) begin
            rsp_d.hit         = 1'b1;
            rsp_d.out_used    = entry_used_q[hit_idx];
            rsp_d.out_payload = PAYLOAD_W'(entry_payload_q[hit_idx]);
            entry_age_d[hit_idx] = ticket;
            age_counter_d        = ticket;
          end
        end
        FUNC_INSERT: begin
          do_insert              = 1'b1;
          entry_slot_d[victim]   = req_q.slot;
          entry_used_d[victim]   = req_q.in_used;
          entry_age_d[victim]    = ticket;
          age_counter_d          = ticket;
        end
        FUNC_INVAL: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
              entry_age_d[i] = '0;
            end
          end
        end
        FUNC_INVAL_ALL: begin
          for (int i = 0; i < ENTRIES; i++) begin
            entry_age_d[i] = '0;
          end
        end
        default: begin
          rsp_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_slot_q[i] <= '0;
        entry_age_q[i]  <= '0;
      end
      entry_used_q  <= '0;
      age_counter_q <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      entry_slot_q  <= entry_slot_d;
      entry_used_q  <= entry_used_d;
      entry_age_q   <= entry_age_d;
      age_counter_q <= age_counter_d;
      rsp_valid_q   <= req_valid_q;
    end
  end

  // payload storage, read only after an insert has filled the entry
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      entry_payload_q[victim] <= req_q.in_payload[PAYLOAD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
